FILE: src/rrs_pkg.sv
`default_nettype none
package rrs_pkg;
	localparam int TaskW = 32;
	localparam int OwnerW = 3;
	localparam int RetryW = 8;
	localparam int PeriodW = 16;
	localparam int TimeW = 32;
	localparam logic [RetryW-1:0] RetriesForever = 8'd255;
	localparam logic [7:0] PopIntervalReset = 8'd6;

	typedef enum logic [1:0] {
		KIND_SET = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_SERVICE = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PUSH = 6'b000010,
		ST_SCAN = 6'b000100,
		ST_POP = 6'b001000,
		ST_READ = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	typedef struct packed {
		logic start;
		logic push_in;
		logic scan_step;
		logic pop;
		logic read_head;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic pop_due;
	} sts_t;
endpackage
`default_nettype wire

FILE: src/rrs_ram.sv
`default_nettype none
module rrs_ram #(
	parameter int Width = 35,
	parameter int Depth = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: src/rrs_ctrl.sv
`default_nettype none
module rrs_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic [1:0] in_kind,
	input wire logic owner_ok,
	input wire logic out_busy,
	input wire rrs_pkg::sts_t sts,
	output rrs_pkg::cmd_t cmd,
	output logic in_ready
);
	import rrs_pkg::*;
	state_t state_q;
	kind_t kind_q;
	logic ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= KIND_NONE;
			ok_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) begin
					kind_q <= kind_t'(in_kind);
					ok_q <= owner_ok;
					state_q <= ST_PUSH;
				end
				ST_PUSH: state_q <= (kind_q == KIND_NONE ||
					(kind_q != KIND_SERVICE && !ok_q)) ? ST_DONE : ST_SCAN;
				ST_SCAN: if (sts.scan_last)
					state_q <= (kind_q == KIND_SERVICE) ? ST_POP : ST_DONE;
				ST_POP: state_q <= sts.pop_due ? ST_READ : ST_DONE;
				ST_READ: state_q <= ST_DONE;
				ST_DONE: if (!out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.start = (state_q == ST_IDLE) && in_fire;
		cmd.push_in = (state_q == ST_PUSH) && kind_q == KIND_SET && ok_q;
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.pop = (state_q == ST_POP);
		cmd.read_head = (state_q == ST_READ);
		cmd.finish = (state_q == ST_DONE) && !out_busy;
	end
	assign in_ready = (state_q == ST_IDLE);
endmodule
`default_nettype wire

FILE: src/rrs_dp.sv
`default_nettype none
module rrs_dp #(
	parameter int REQUEST_SLOTS = 8,
	parameter int OWNER_COUNT = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire rrs_pkg::cmd_t cmd,
	output rrs_pkg::sts_t sts,
	input wire logic [1:0] in_kind,
	input wire logic [2:0] in_owner,
	input wire logic [31:0] in_task,
	input wire logic [7:0] in_retries,
	input wire logic [15:0] in_period,
	input wire logic [31:0] in_now,
	input wire logic [7:0] pop_interval,
	output logic owner_ok,
	output logic [68:0] res_data,
	output logic res_valid,
	input wire logic res_ready
);
	import rrs_pkg::*;
	localparam int SW = (REQUEST_SLOTS > 1) ? $clog2(REQUEST_SLOTS) : 1;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [TaskW-1:0] slot_task_q [REQUEST_SLOTS];
	logic [OwnerW-1:0] slot_owner_q [REQUEST_SLOTS];
	logic [RetryW-1:0] slot_retries_q [REQUEST_SLOTS];
	logic [TimeW-1:0] slot_last_q [REQUEST_SLOTS];
	logic [PeriodW-1:0] slot_period_q [REQUEST_SLOTS];
	logic [TaskW-1:0] waiting_q [OWNER_COUNT];
	logic [CW-1:0] count_q;
	logic [QW-1:0] head_q;
	logic [TimeW-1:0] last_pop_q;

	kind_t kind_q;
	logic [OwnerW-1:0] owner_q;
	logic [TaskW-1:0] task_q;
	logic [RetryW-1:0] retries_q;
	logic [PeriodW-1:0] period_q;
	logic [TimeW-1:0] now_q;
	logic ok_q;
	logic [SW-1:0] idx_q;
	logic found_q, have_free_q, ovf_q, popped_q;
	logic [SW-1:0] free_q;
	logic [OwnerW-1:0] pop_owner_q;
	logic [TaskW-1:0] pop_task_q;

	logic push_en;
	logic [OwnerW-1:0] push_owner;
	logic [TaskW-1:0] push_task;
	logic [CW:0] wsum;
	logic [QW-1:0] waddr;
	logic [OwnerW+TaskW-1:0] rdata;

	logic match, busy_slot, due, pop_ok;
	logic [TimeW-1:0] age;
	logic [RetryW-1:0] dec;

	assign owner_ok = 32'(in_owner) < OWNER_COUNT;
	assign match = slot_owner_q[idx_q] == owner_q && slot_task_q[idx_q] == task_q;
	assign busy_slot = slot_task_q[idx_q] != '0;
	assign age = now_q - slot_last_q[idx_q];
	assign due = busy_slot && (age >= 32'(slot_period_q[idx_q]));
	assign dec = (slot_retries_q[idx_q] != '0) ? slot_retries_q[idx_q] - 8'd1 : '0;
	assign pop_ok = (now_q - last_pop_q) > 32'(pop_interval);

	always_comb begin
		push_en = 1'b0;
		push_owner = owner_q;
		push_task = task_q;
		if (cmd.push_in) push_en = 1'b1;
		if (cmd.scan_step && kind_q == KIND_SERVICE && due) begin
			push_en = 1'b1;
			push_owner = slot_owner_q[idx_q];
			push_task = slot_task_q[idx_q];
		end
	end
	assign wsum = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign waddr = (32'(wsum) >= QUEUE_DEPTH) ? QW'(32'(wsum) - QUEUE_DEPTH) : QW'(wsum);

	rrs_ram #(.Width(OwnerW + TaskW), .Depth(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.we(push_en && 32'(count_q) < QUEUE_DEPTH),
		.waddr(waddr),
		.wdata({push_owner, push_task}),
		.raddr(head_q),
		.rdata(rdata)
	);

	assign sts.scan_last = 32'(idx_q) == REQUEST_SLOTS - 1;
	assign sts.pop_due = pop_ok && count_q != '0;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q <= kind_t'(in_kind);
			owner_q <= in_owner;
			task_q <= in_task;
			retries_q <= in_retries;
			period_q <= in_period;
			now_q <= in_now;
			ok_q <= owner_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REQUEST_SLOTS; i++) begin
				slot_task_q[i] <= '0;
				slot_owner_q[i] <= '0;
				slot_retries_q[i] <= '0;
				slot_last_q[i] <= '0;
				slot_period_q[i] <= '0;
			end
			for (int i = 0; i < OWNER_COUNT; i++) waiting_q[i] <= '0;
			count_q <= '0;
			head_q <= '0;
			last_pop_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			have_free_q <= 1'b0;
			free_q <= '0;
			ovf_q <= 1'b0;
			popped_q <= 1'b0;
			pop_owner_q <= '0;
			pop_task_q <= '0;
			res_valid <= 1'b0;
			res_data <= '0;
		end else begin
			if (cmd.start) begin
				idx_q <= '0;
				found_q <= 1'b0;
				have_free_q <= 1'b0;
				ovf_q <= 1'b0;
				popped_q <= 1'b0;
				pop_owner_q <= '0;
				pop_task_q <= '0;
				if (kind_t'(in_kind) == KIND_SERVICE)
					for (int i = 0; i < OWNER_COUNT; i++) waiting_q[i] <= '0;
			end
			if (push_en) begin
				if (32'(count_q) < QUEUE_DEPTH) count_q <= count_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (cmd.push_in) waiting_q[owner_q] <= waiting_q[owner_q] | task_q;
			if (cmd.scan_step) begin
				if (!sts.scan_last) idx_q <= idx_q + 1'b1;
				unique case (kind_q)
					KIND_SET: if (retries_q != '0 && !found_q) begin
						if (match) found_q <= 1'b1;
						else if (!have_free_q && !busy_slot) begin
							have_free_q <= 1'b1;
							free_q <= idx_q;
						end
						if (sts.scan_last && !match) begin
							if (!have_free_q && !busy_slot) begin
								slot_task_q[idx_q] <= task_q;
								slot_owner_q[idx_q] <= owner_q;
								slot_retries_q[idx_q] <= retries_q;
								slot_last_q[idx_q] <= now_q;
								slot_period_q[idx_q] <= period_q;
							end else if (have_free_q) begin
								slot_task_q[free_q] <= task_q;
								slot_owner_q[free_q] <= owner_q;
								slot_retries_q[free_q] <= retries_q;
								slot_last_q[free_q] <= now_q;
								slot_period_q[free_q] <= period_q;
							end
						end
					end
					KIND_CLEAR: if (match) begin
						slot_task_q[idx_q] <= '0;
						waiting_q[owner_q] <= waiting_q[owner_q] & ~task_q;
					end
					KIND_SERVICE: if (busy_slot) begin
						if (32'(slot_owner_q[idx_q]) < OWNER_COUNT)
							waiting_q[slot_owner_q[idx_q]] <=
								waiting_q[slot_owner_q[idx_q]] | slot_task_q[idx_q];
						if (due) begin
							slot_last_q[idx_q] <= now_q;
							if (slot_retries_q[idx_q] != RetriesForever) begin
								slot_retries_q[idx_q] <= dec;
								if (dec == '0) slot_task_q[idx_q] <= '0;
							end
						end
					end
					default: ;
				endcase
			end
			if (cmd.pop && pop_ok) begin
				last_pop_q <= now_q;
				if (count_q != '0) count_q <= count_q - 1'b1;
			end
			if (cmd.read_head) begin
				popped_q <= 1'b1;
				pop_owner_q <= rdata[OwnerW+TaskW-1:TaskW];
				pop_task_q <= rdata[TaskW-1:0];
				head_q <= (32'(head_q) == QUEUE_DEPTH - 1) ? '0 : head_q + 1'b1;
			end
			if (cmd.finish) begin
				res_valid <= 1'b1;
				res_data <= {ovf_q, ok_q ? waiting_q[owner_q] : 32'd0,
					pop_task_q, pop_owner_q, popped_q};
			end else if (res_valid && res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/retry_request_scheduler.sv
`default_nettype none
// Retry request scheduler: keeps a table of pending requests and a task queue.
// One transaction in gives one transaction out; the kind travels on s_tuser.
// A set or clear with a valid owner walks the slot table once before the block is
// ready again, a service pass walks it and then visits the pop state, and also a
// head-read state when it pops; an unused kind skips the walk. The controller walks
// the slot table one slot per cycle, and the popped head is taken from the queue
// RAM's registered read in that head-read state.
// A result waits in the output register while the next transaction is taken;
// that transaction's result is held back, and the input stalls, until the
// register is free. Write pop_interval only while idle.
module retry_request_scheduler #(
	parameter int REQUEST_SLOTS = 8,
	parameter int OWNER_COUNT = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// owner_index[2:0] task_bits[34:3] retries[42:35] resend_period[58:43]
	// now[90:59]
	input wire logic [95:0] s_tdata,
	// kind[1:0]
	input wire logic [1:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// popped_valid[0] popped_owner[3:1] popped_task[35:4] waiting_mask[67:36]
	// queue_overflow[68]
	output logic [71:0] m_tdata,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import rrs_pkg::*;
	cmd_t cmd;
	sts_t sts;
	logic owner_ok, in_fire;
	logic [7:0] pop_interval_q;
	logic [68:0] res;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {24'd0, pop_interval_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pop_interval_q <= PopIntervalReset;
		else if (psel && penable && pwrite && paddr == 2'd0) pop_interval_q <= pwdata[7:0];
	end

	assign in_fire = s_tvalid && s_tready;

	rrs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_kind(s_tuser),
		.owner_ok(owner_ok), .out_busy(m_tvalid && !m_tready), .sts(sts),
		.cmd(cmd), .in_ready(s_tready)
	);

	rrs_dp #(.REQUEST_SLOTS(REQUEST_SLOTS), .OWNER_COUNT(OWNER_COUNT),
		.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_kind(s_tuser), .in_owner(s_tdata[2:0]), .in_task(s_tdata[34:3]),
		.in_retries(s_tdata[42:35]), .in_period(s_tdata[58:43]),
		.in_now(s_tdata[90:59]), .pop_interval(pop_interval_q), .owner_ok(owner_ok),
		.res_data(res), .res_valid(m_tvalid), .res_ready(m_tready)
	);
	assign m_tdata = {3'd0, res};
endmodule
`default_nettype wire

FILE: src/rrs_checker.sv
`default_nettype none
module rrs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [71:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction taken while busy");
	a_nopop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[35:1] == 35'd0)
		else $error("popped fields set without pop");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:69] == 3'd0)
		else $error("result padding bits set");
endmodule
bind retry_request_scheduler rrs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none
class retry_sched_scoreboard;
	bit [31:0] slot_task [8];
	bit [2:0] slot_owner [8];
	bit [7:0] slot_retries [8];
	bit [31:0] slot_last_sent [8];
	bit [15:0] slot_period [8];
	bit [31:0] owner_waiting [8];
	bit [34:0] task_queue [$];
	bit [31:0] last_pop_time;
	bit [7:0] pop_interval;
	bit [68:0] expected_results [$];
	int fail_count;

	function new();
		pop_interval = rrs_pkg::PopIntervalReset;
	endfunction

	function bit enqueue_task(bit [2:0] owner, bit [31:0] bits);
		if (task_queue.size() >= 16) return 1'b1;
		task_queue.push_back({bits, owner});
		return 1'b0;
	endfunction

	function void note_request(rrs_pkg::kind_t kind, bit [2:0] owner, bit [31:0] bits,
			bit [7:0] retries, bit [15:0] period, bit [31:0] now);
		bit ovf;
		bit found;
		bit have_free;
		int free_i;
		bit popped;
		bit [34:0] head;
		ovf = 0;
		popped = 0;
		head = '0;
		found = 0;
		have_free = 0;
		free_i = 0;
		if (kind == rrs_pkg::KIND_SET) begin
			ovf |= enqueue_task(owner, bits);
			owner_waiting[owner] |= bits;
			if (retries != 0) begin
				for (int i = 0; i < 8; i++) begin
					if (slot_owner[i] == owner && slot_task[i] == bits) begin
						found = 1;
						break;
					end
					if (!have_free && slot_task[i] == 0) begin
						have_free = 1;
						free_i = i;
					end
				end
				if (!found && have_free) begin
					slot_task[free_i] = bits;
					slot_owner[free_i] = owner;
					slot_retries[free_i] = retries;
					slot_last_sent[free_i] = now;
					slot_period[free_i] = period;
				end
			end
		end else if (kind == rrs_pkg::KIND_CLEAR) begin
			for (int i = 0; i < 8; i++)
				if (slot_owner[i] == owner && slot_task[i] == bits) begin
					slot_task[i] = 0;
					owner_waiting[owner] &= ~bits;
				end
		end else if (kind == rrs_pkg::KIND_SERVICE) begin
			for (int i = 0; i < 8; i++) owner_waiting[i] = 0;
			for (int i = 0; i < 8; i++) begin
				if (slot_task[i] == 0) continue;
				owner_waiting[slot_owner[i]] |= slot_task[i];
				if (32'(now - slot_last_sent[i]) >= slot_period[i]) begin
					ovf |= enqueue_task(slot_owner[i], slot_task[i]);
					slot_last_sent[i] = now;
					if (slot_retries[i] < rrs_pkg::RetriesForever) begin
						if (slot_retries[i] != 0) slot_retries[i]--;
						if (slot_retries[i] == 0) slot_task[i] = 0;
					end
				end
			end
			if (32'(now - last_pop_time) > pop_interval) begin
				last_pop_time = now;
				if (task_queue.size() != 0) begin
					popped = 1;
					head = task_queue.pop_front();
				end
			end
		end
		expected_results.push_back({ovf, owner_waiting[owner], head[34:3], head[2:0], popped});
	endfunction

	function void check_result(bit [68:0] got);
		bit [68:0] want;
		if (expected_results.size() == 0) begin
			$error("unexpected result %h", got);
			fail_count++;
			return;
		end
		want = expected_results.pop_front();
		if (got[0] !== want[0]) begin
			$error("popped_valid expected %0d actual %0d", want[0], got[0]);
			fail_count++;
		end
		if (got[3:1] !== want[3:1]) begin
			$error("popped_owner expected %0d actual %0d", want[3:1], got[3:1]);
			fail_count++;
		end
		if (got[35:4] !== want[35:4]) begin
			$error("popped_task expected %h actual %h", want[35:4], got[35:4]);
			fail_count++;
		end
		if (got[67:36] !== want[67:36]) begin
			$error("waiting_mask expected %h actual %h", want[67:36], got[67:36]);
			fail_count++;
		end
		if (got[68] !== want[68]) begin
			$error("queue_overflow expected %0d actual %0d", want[68], got[68]);
			fail_count++;
		end
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rrs_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	// owner_index task_bits retries resend_period now
	logic [95:0] s_tdata = '0;
	// kind
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	// popped_valid popped_owner popped_task waiting_mask queue_overflow
	logic [71:0] m_tdata;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	retry_sched_scoreboard sched_model = new();
	bit [31:0] tick;
	bit [31:0] known_tasks [4];
	bit hold_off = 0;
	int cycles = 0;

	retry_request_scheduler dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("tb_top failed");
			$finish;
		end
	end

	always @(posedge clk)
		if (m_tvalid && m_tready) sched_model.check_result(m_tdata[68:0]);

	// result side stalls
	always @(negedge clk) begin
		if (hold_off) m_tready <= 0;
		else if ($urandom_range(0, 9) < 3) m_tready <= 0;
		else if ($urandom_range(0, 60) == 0) begin
			m_tready <= 0;
			repeat ($urandom_range(20, 60)) @(negedge clk);
			m_tready <= 1;
		end else m_tready <= 1;
	end

	task automatic write_interval(bit [7:0] value);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= '0;
		pwdata <= {24'd0, value};
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sched_model.pop_interval = value;
	endtask

	task automatic send_request(kind_t kind, bit [2:0] owner, bit [31:0] bits,
			bit [7:0] retries, bit [15:0] period);
		@(negedge clk);
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {5'b0, tick, period, retries, bits, owner};
		sched_model.note_request(kind, owner, bits, retries, period, tick);
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid <= 0;
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) @(negedge clk);
		else if ($urandom_range(0, 50) == 0) repeat ($urandom_range(20, 50)) @(negedge clk);
	endtask

	task automatic drain();
		while (sched_model.expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_request();
		int pick;
		bit [2:0] owner;
		bit [31:0] bits;
		pick = $urandom_range(0, 99);
		owner = 3'($urandom_range(0, 3));
		bits = $urandom_range(0, 1) ? known_tasks[$urandom_range(0, 3)] : $urandom;
		tick += $urandom_range(0, 5) == 0 ? $urandom_range(0, 300) : $urandom_range(0, 4);
		if (pick < 40)
			send_request(KIND_SET, owner, bits,
				$urandom_range(0, 4) == 0 ? 8'd255 : 8'($urandom_range(0, 5)),
				$urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 12)));
		else if (pick < 52)
			send_request(KIND_CLEAR, owner, bits, 8'($urandom), 16'($urandom));
		else if (pick < 97)
			send_request(KIND_SERVICE, 3'($urandom), $urandom, 8'($urandom), 16'($urandom));
		else send_request(KIND_NONE, 3'($urandom), $urandom, 8'($urandom), 16'($urandom));
	endtask

	initial begin
		foreach (known_tasks[i]) known_tasks[i] = $urandom | 1;
		tick = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed part
		send_request(KIND_SET, 3'd7, 32'hFFFF_FFFF, 8'd255, 16'hFFFF);
		send_request(KIND_SET, 3'd0, 32'h0, 8'd3, 16'd0);
		send_request(KIND_SET, 3'd1, 32'h1, 8'd2, 16'd0);
		send_request(KIND_SET, 3'd1, 32'h1, 8'd2, 16'd0);
		send_request(KIND_SET, 3'd2, 32'h8000_0000, 8'd0, 16'd5);
		for (int i = 0; i < 8; i++) send_request(KIND_SET, 3'd3, 32'(1 << (i + 4)), 8'd1, 16'd1);
		tick = 32'hFFFF_FFF0;
		send_request(KIND_SERVICE, 3'd1, '0, '0, '0);
		tick = 32'h0000_0010;
		send_request(KIND_SERVICE, 3'd7, '0, '0, '0);
		send_request(KIND_CLEAR, 3'd7, 32'hFFFF_FFFF, '0, '0);
		send_request(KIND_NONE, 3'd1, '0, '0, '0);
		for (int i = 0; i < 6; i++) send_request(KIND_SET, 3'd4, $urandom, 8'd0, '0);
		tick = 32'hFFFF_FFFF;
		send_request(KIND_SERVICE, 3'd4, '0, '0, '0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_interval(ph == 0 ? 8'd0 : ph == 1 ? 8'd255 : 8'($urandom_range(1, 10)));
			if (ph == 2) begin
				hold_off = 1;
				fork
					begin
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
					repeat (20) random_request();
				join
			end
			repeat (270) random_request();
			drain();
		end
		if (sched_model.fail_count == 0) $display("tb_top passed");
		else $display("tb_top failed");
		$finish;
	end
endmodule
`default_nettype wire
